### hdl/jsch_pkg.sv
`default_nettype none
package jsch_pkg;

  localparam int MaxJobsDefault = 16;

  localparam int IdW    = 8;
  localparam int BurstW = 16;
  localparam int WaitW  = 16;
  localparam int TickW  = 32;
  localparam int CntW   = 5;

  // scheduling modes
  localparam logic [1:0] ModeFcfs = 2'd0;
  localparam logic [1:0] ModeSjf  = 2'd1;
  localparam logic [1:0] ModeRr   = 2'd2;

  // configuration register indexes
  localparam logic CfgMode    = 1'b0;
  localparam logic CfgQuantum = 1'b1;

  // item kinds
  localparam logic KindArrival = 1'b0;
  localparam logic KindTick    = 1'b1;

  localparam logic [7:0] QuantumReset = 8'd2;

  typedef struct packed {
    logic [WaitW-1:0]  wait_cnt;
    logic [BurstW-1:0] remaining;
    logic [IdW-1:0]    id;
  } entry_t;

endpackage
`default_nettype wire

### hdl/job_scheduler_fcfs_sjf_rr.sv
// Job scheduler with a ready table, first come first served, shortest job
// first (non-preemptive) or round robin, chosen by the sched_mode register.
// Input channel s_axis: tuser is the kind (0 arrival, 1 tick), tdata holds
// job_id and burst_len. Each input word gives exactly one result word on
// m_axis. Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must write it only while the block is idle; the block does not enforce it.
// An arrival is written into the table on acceptance. A tick walks the table in a
// single memory with one read and one write port, one entry per cycle: an
// update pass, before it a minimum scan in SJF with no running job or a round
// robin rotation once the slice is used up, and after it, for a finished job,
// a compaction pass. s_axis_tready is high only between items.
// The result sits in an output register; the next word is accepted while it
// waits, and the block holds its last state until m_axis_tready frees it.
// Reset empties the table, clears the tick count and slice counter and sets
// sched_mode to FCFS and time_quantum to 2; table memory is not cleared.
`default_nettype none
module job_scheduler_fcfs_sjf_rr #(
  parameter int MaxJobs = jsch_pkg::MaxJobsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // job_id [7:0], burst_len [23:8]
  input  wire logic [23:0] s_axis_tdata,
  // kind
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // accepted [0], ran_valid [1], ran_id [9:2], finished [10],
  // finished_wait [26:11], queued_count [31:27], tick_number [63:32]
  output logic [63:0]      m_axis_tdata
);

  localparam int IW = $clog2(MaxJobs);
  localparam int CW = $clog2(MaxJobs + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StScan  = 4'd1;
  localparam logic [3:0] StRotRd = 4'd2;
  localparam logic [3:0] StRotSv = 4'd3;
  localparam logic [3:0] StShift = 4'd4;
  localparam logic [3:0] StRotWr = 4'd5;
  localparam logic [3:0] StUpd   = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] run_q, run_d;
  logic          run_vld_q, run_vld_d;
  logic [7:0]    slice_q, slice_d;
  logic [31:0]   tick_q, tick_d;
  logic [1:0]    mode_q;
  logic [7:0]    tq_q;

  logic [CW-1:0] rd_q, rd_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic [IW-1:0] slot_q, slot_d;
  logic          same_q, same_d;
  logic [15:0]   best_q, best_d;
  logic          rot_q, rot_d;
  logic          fin_q, fin_d;
  logic          acc_q, acc_d;
  logic          ranv_q, ranv_d;
  logic [7:0]    ran_id_q, ran_id_d;
  logic [15:0]   fwait_q, fwait_d;
  logic [31:0]   tickb_q, tickb_d;
  jsch_pkg::entry_t saved_q, saved_d;

  logic          ovalid_q, ovalid_d;
  logic [63:0]   odata_q, odata_d;

  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [IW-1:0]    mem_ra;
  jsch_pkg::entry_t mem_wd;
  jsch_pkg::entry_t mem_rd;

  logic          in_acc;
  logic          pass_st;
  logic          issue;
  logic          pass_done;
  logic          run_ok;
  logic [7:0]    quantum;
  logic [CW-1:0] fill_m1;
  logic [15:0]   new_rem;
  logic [31:0]   fill_ext;

  jsch_mem #(.Depth(MaxJobs), .AddrW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign pass_st   = (state_q == StScan) || (state_q == StShift) || (state_q == StUpd);
  assign issue     = rd_q < fill_q;
  assign pass_done = pass_st && !issue && !pend_q;
  assign run_ok    = run_vld_q && (CW'(run_q) < fill_q);
  assign quantum   = (tq_q == 8'd0) ? 8'd1 : tq_q;
  assign fill_m1   = fill_q - CW'(1);
  assign new_rem   = mem_rd.remaining - 16'd1;
  assign fill_ext  = 32'(fill_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    run_d     = run_q;
    run_vld_d = run_vld_q;
    slice_d   = slice_q;
    tick_d    = tick_q;
    rd_d      = rd_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    slot_d    = slot_q;
    same_d    = same_q;
    best_d    = best_q;
    rot_d     = rot_q;
    fin_d     = fin_q;
    acc_d     = acc_q;
    ranv_d    = ranv_q;
    ran_id_d  = ran_id_q;
    fwait_d   = fwait_q;
    tickb_d   = tickb_q;
    saved_d   = saved_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;
    mem_we    = 1'b0;
    mem_wa    = fill_q[IW-1:0];
    mem_wd    = mem_rd;
    mem_ra    = rd_q[IW-1:0];

    // one entry read per cycle through the registered read port
    if (pass_st && issue) begin
      rd_d   = rd_q + CW'(1);
      pend_d = 1'b1;
      pidx_d = rd_q[IW-1:0];
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          tickb_d  = tick_q;
          acc_d    = 1'b0;
          ranv_d   = 1'b0;
          fin_d    = 1'b0;
          ran_id_d = 8'd0;
          fwait_d  = 16'd0;
          rot_d    = 1'b0;
          rd_d     = '0;
          state_d  = StOut;
          if (s_axis_tuser == jsch_pkg::KindArrival) begin
            if ((s_axis_tdata[23:8] != 16'd0) && (fill_q < CW'(MaxJobs))) begin
              mem_we         = 1'b1;
              mem_wa         = fill_q[IW-1:0];
              mem_wd.id        = s_axis_tdata[7:0];
              mem_wd.remaining = s_axis_tdata[23:8];
              mem_wd.wait_cnt  = 16'd0;
              fill_d         = fill_q + CW'(1);
              acc_d          = 1'b1;
            end
          end else begin
            tick_d = tick_q + 32'd1;
            if (!run_ok) begin
              run_vld_d = 1'b0;
            end
            if (fill_q != '0) begin
              case (mode_q)
                jsch_pkg::ModeSjf: begin
                  if (run_ok) begin
                    slot_d  = run_q;
                    same_d  = 1'b1;
                    state_d = StUpd;
                  end else begin
                    state_d = StScan;
                  end
                end
                jsch_pkg::ModeRr: begin
                  if (run_ok && (slice_q >= quantum)) begin
                    rot_d     = 1'b1;
                    run_vld_d = 1'b0;
                    state_d   = StRotRd;
                  end else begin
                    slot_d  = run_ok ? run_q : '0;
                    same_d  = run_ok;
                    state_d = StUpd;
                  end
                end
                default: begin
                  slot_d  = '0;
                  same_d  = run_ok && (run_q == '0);
                  state_d = StUpd;
                end
              endcase
            end
          end
        end
      end
      StScan: begin
        if (pend_q && ((pidx_q == '0) || (mem_rd.remaining < best_q))) begin
          best_d = mem_rd.remaining;
          slot_d = pidx_q;
        end
        if (pass_done) begin
          same_d  = 1'b0;
          rd_d    = '0;
          state_d = StUpd;
        end
      end
      StRotRd: begin
        mem_ra  = run_q;
        state_d = StRotSv;
      end
      StRotSv: begin
        saved_d = mem_rd;
        rd_d    = CW'(run_q) + CW'(1);
        state_d = StShift;
      end
      StShift: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pidx_q - IW'(1);
          mem_wd = mem_rd;
        end
        if (pass_done) begin
          if (rot_q) begin
            state_d = StRotWr;
          end else begin
            fill_d  = fill_m1;
            state_d = StOut;
          end
        end
      end
      StRotWr: begin
        mem_we  = 1'b1;
        mem_wa  = fill_m1[IW-1:0];
        mem_wd  = saved_q;
        rot_d   = 1'b0;
        slot_d  = '0;
        same_d  = 1'b0;
        rd_d    = '0;
        state_d = StUpd;
      end
      StUpd: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pidx_q;
          if (pidx_q == slot_q) begin
            mem_wd.remaining = new_rem;
            ranv_d   = 1'b1;
            ran_id_d = mem_rd.id;
            if (new_rem == 16'd0) begin
              fin_d   = 1'b1;
              fwait_d = mem_rd.wait_cnt;
            end
          end else if (mem_rd.wait_cnt != 16'hFFFF) begin
            mem_wd.wait_cnt = mem_rd.wait_cnt + 16'd1;
          end
        end
        if (pass_done) begin
          if (fin_q) begin
            run_vld_d = 1'b0;
            slice_d   = 8'd0;
            rd_d      = CW'(slot_q) + CW'(1);
            state_d   = StShift;
          end else begin
            run_vld_d = 1'b1;
            run_d     = slot_q;
            if (!same_q) begin
              slice_d = 8'd1;
            end else if (slice_q != 8'hFF) begin
              slice_d = slice_q + 8'd1;
            end
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {tickb_q, fill_ext[4:0], fwait_q, fin_q, ran_id_q, ranv_q, acc_q};
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      run_vld_q <= 1'b0;
      slice_q   <= 8'd0;
      tick_q    <= 32'd0;
      mode_q    <= jsch_pkg::ModeFcfs;
      tq_q      <= jsch_pkg::QuantumReset;
      pend_q    <= 1'b0;
      rot_q     <= 1'b0;
      fin_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      run_vld_q <= run_vld_d;
      slice_q   <= slice_d;
      tick_q    <= tick_d;
      pend_q    <= pend_d;
      rot_q     <= rot_d;
      fin_q     <= fin_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jsch_pkg::CfgMode:    mode_q <= cfg_data_i[1:0];
          jsch_pkg::CfgQuantum: tq_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q    <= run_d;
    rd_q     <= rd_d;
    pidx_q   <= pidx_d;
    slot_q   <= slot_d;
    same_q   <= same_d;
    best_q   <= best_d;
    acc_q    <= acc_d;
    ranv_q   <= ranv_d;
    ran_id_q <= ran_id_d;
    fwait_q  <= fwait_d;
    tickb_q  <= tickb_d;
    saved_q  <= saved_d;
    odata_q  <= odata_d;
  end

  // table never overfills
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MaxJobs))
    else $error("ready table fill above capacity");

  // between items a running job always points inside the table
  a_run_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && run_vld_q) |-> (CW'(run_q) < fill_q))
    else $error("running slot outside the table");

  // a tick word advances the tick count by exactly one
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == jsch_pkg::KindTick) |=> (tick_q == $past(tick_q) + 32'd1))
    else $error("tick count did not advance");

endmodule
`default_nettype wire

### hdl/jsch_mem.sv
`default_nettype none
module jsch_mem #(
  parameter int Depth = jsch_pkg::MaxJobsDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire jsch_pkg::entry_t   wdata_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output jsch_pkg::entry_t        rdata_o
);

  jsch_pkg::entry_t mem [Depth];
  jsch_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int Depth = jsch_pkg::MaxJobsDefault;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  job_scheduler_fcfs_sjf_rr uut (.*);

  typedef struct packed {
    logic [31:0] tick_number;
    logic [4:0]  queued_count;
    logic [15:0] finished_wait;
    logic        finished;
    logic [7:0]  ran_id;
    logic        ran_valid;
    logic        accepted;
  } outcome_t;

  // scheduler shadow state
  logic [7:0]  sh_id [Depth];
  logic [15:0] sh_rem [Depth];
  logic [15:0] sh_wait [Depth];
  int          sh_fill;
  int          sh_running;
  int          sh_slice;
  logic [31:0] sh_ticks;
  logic [1:0]  sh_mode;
  logic [7:0]  sh_quantum;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycles = 0;
  int burst_left = 0;
  int n_finished = 0;
  int n_refused = 0;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch word %0d: %s got %0h expected %0h", words_checked, what, got, want);
  endtask

  function automatic void close_slot(input int s);
    for (int k = s; k + 1 < sh_fill; k++) begin
      sh_id[k] = sh_id[k+1];
      sh_rem[k] = sh_rem[k+1];
      sh_wait[k] = sh_wait[k+1];
    end
    sh_fill--;
  endfunction

  function automatic outcome_t predict_schedule(input logic kind, input logic [7:0] id,
                                                input logic [15:0] burst);
    outcome_t o;
    int slot;
    int q;
    logic [7:0] t_id;
    logic [15:0] t_rem, t_wait;
    o = '0;
    o.tick_number = sh_ticks;
    if (kind == jsch_pkg::KindArrival) begin
      if (burst != 0 && sh_fill < Depth) begin
        sh_id[sh_fill] = id;
        sh_rem[sh_fill] = burst;
        sh_wait[sh_fill] = '0;
        sh_fill++;
        o.accepted = 1'b1;
      end
    end else begin
      sh_ticks++;
      if (sh_running >= sh_fill) sh_running = -1;
      if (sh_fill > 0) begin
        if (sh_mode == jsch_pkg::ModeSjf) begin
          if (sh_running >= 0) slot = sh_running;
          else begin
            slot = 0;
            for (int k = 1; k < sh_fill; k++) if (sh_rem[k] < sh_rem[slot]) slot = k;
          end
        end else if (sh_mode == jsch_pkg::ModeRr) begin
          q = (sh_quantum == 0) ? 1 : sh_quantum;
          if (sh_running >= 0 && sh_slice >= q) begin
            t_id = sh_id[sh_running];
            t_rem = sh_rem[sh_running];
            t_wait = sh_wait[sh_running];
            close_slot(sh_running);
            sh_id[sh_fill] = t_id;
            sh_rem[sh_fill] = t_rem;
            sh_wait[sh_fill] = t_wait;
            sh_fill++;
            sh_running = -1;
          end
          slot = (sh_running >= 0) ? sh_running : 0;
        end else begin
          slot = 0;
        end
        if (slot != sh_running) sh_slice = 0;
        sh_running = slot;
        if (sh_slice < 255) sh_slice++;
        o.ran_valid = 1'b1;
        o.ran_id = sh_id[slot];
        sh_rem[slot]--;
        for (int k = 0; k < sh_fill; k++)
          if (k != slot && sh_wait[k] != 16'hFFFF) sh_wait[k]++;
        if (sh_rem[slot] == 0) begin
          o.finished = 1'b1;
          o.finished_wait = sh_wait[slot];
          close_slot(slot);
          sh_running = -1;
          sh_slice = 0;
        end
      end
    end
    o.queued_count = 5'(sh_fill);
    return o;
  endfunction

  // receiver: stall pattern, then compare at the rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else case (($urandom >> 4) % 8)
      0, 1: m_axis_tready <= 1'b0;
      default: m_axis_tready <= (cycles % 512 < 64) ? 1'b1 : ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.accepted != want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
        if (got.ran_valid != want.ran_valid)
          report_mismatch("ran_valid", got.ran_valid, want.ran_valid);
        if (got.ran_id != want.ran_id) report_mismatch("ran_id", got.ran_id, want.ran_id);
        if (got.finished != want.finished) report_mismatch("finished", got.finished, want.finished);
        if (got.finished_wait != want.finished_wait)
          report_mismatch("finished_wait", got.finished_wait, want.finished_wait);
        if (got.queued_count != want.queued_count)
          report_mismatch("queued_count", got.queued_count, want.queued_count);
        if (got.tick_number != want.tick_number)
          report_mismatch("tick_number", got.tick_number, want.tick_number);
      end
      words_checked++;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] id, input logic [15:0] burst);
    outcome_t o;
    // bursty sender with random gaps
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {burst, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    o = predict_schedule(kind, id, burst);
    if (kind == jsch_pkg::KindArrival && !o.accepted) n_refused++;
    if (o.finished) n_finished++;
    pending_outcomes.push_back(o);
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == jsch_pkg::CfgMode) sh_mode = value[1:0];
    else sh_quantum = value;
  endtask

  task automatic tick();
    send_word(jsch_pkg::KindTick, 8'($urandom), 16'($urandom));
  endtask

  task automatic arrive(input logic [7:0] id, input logic [15:0] burst);
    send_word(jsch_pkg::KindArrival, id, burst);
  endtask

  task automatic test_directed();
    tick();                      // empty table
    arrive(8'h00, 16'h0000);     // zero burst refused
    arrive(8'hFF, 16'h0003);
    arrive(8'hA5, 16'h0001);
    arrive(8'h5A, 16'h0002);
    repeat (4) tick();
    for (int i = 0; i < 17; i++) arrive(8'(i + 1), 16'(i % 3 + 1)); // overfill
    arrive(8'hFF, 16'hFFFF);     // full table refused
    drain_results();
  endtask

  task automatic test_sjf();
    write_reg(jsch_pkg::CfgMode, {6'd0, jsch_pkg::ModeSjf});
    repeat (20) tick();
    arrive(8'h77, 16'hFFFF);
    arrive(8'h78, 16'h8000);
    repeat (10) tick();
  endtask

  task automatic test_rr();
    write_reg(jsch_pkg::CfgMode, {6'd0, jsch_pkg::ModeRr});
    write_reg(jsch_pkg::CfgQuantum, 8'd1);
    repeat (8) tick();
    write_reg(jsch_pkg::CfgQuantum, 8'd0);
    repeat (6) tick();
    write_reg(jsch_pkg::CfgQuantum, 8'd255);
    repeat (6) tick();
    // mode switch with a job mid-run
    write_reg(jsch_pkg::CfgMode, {6'd0, jsch_pkg::ModeFcfs});
    repeat (4) tick();
    write_reg(jsch_pkg::CfgMode, 8'd3);
    repeat (4) tick();
  endtask

  task automatic random_phase(input int n, input logic [1:0] mode, input logic [7:0] q);
    int r;
    write_reg(jsch_pkg::CfgMode, {6'd0, mode});
    write_reg(jsch_pkg::CfgQuantum, q);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) tick();
      else if (r < 44) arrive(8'($urandom), 16'd0);
      else if (r < 48) arrive(8'($urandom), 16'($urandom));
      else arrive(8'($urandom), 16'($urandom_range(1, 8)));
    end
  endtask

  task automatic test_random();
    random_phase(90, jsch_pkg::ModeFcfs, 8'd2);
    random_phase(90, jsch_pkg::ModeSjf, 8'd2);
    random_phase(90, jsch_pkg::ModeRr, 8'($urandom_range(1, 4)));
    drain_results();             // pause until all results are back
    random_phase(90, jsch_pkg::ModeRr, 8'($urandom_range(0, 255)));
    random_phase(90, 2'($urandom_range(0, 3)), 8'($urandom_range(1, 3)));
  endtask

  initial begin
    sh_fill = 0;
    sh_running = -1;
    sh_slice = 0;
    sh_ticks = '0;
    sh_mode = jsch_pkg::ModeFcfs;
    sh_quantum = jsch_pkg::QuantumReset;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_sjf();
    test_rr();
    test_random();
    drain_results();
    $display("sent %0d words, checked %0d results over all modes and quanta", words_sent,
             words_checked);
    $display("%0d jobs finished, %0d arrivals refused, %0d mismatches", n_finished, n_refused,
             errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/jsch_pkg.sv
hdl/jsch_mem.sv
hdl/job_scheduler_fcfs_sjf_rr.sv
bench/tb.sv
